[rtl/dbd_pkg.sv]
// Shared types, constants and helpers of the detection box decoder.
`timescale 1ns / 1ps

package dbd_pkg;

  // Prediction format
  localparam int unsigned ClassCount    = 80;
  localparam int unsigned ClassW        = 7;
  localparam int unsigned CoordW        = 16;
  localparam int unsigned ScoreW        = 16;
  localparam int unsigned CoordFracBits = 4;

  // Configuration widths
  localparam int unsigned PadW      = 11;
  localparam int unsigned InvW      = 24;
  localparam int unsigned SizeW     = 14;
  localparam int unsigned MaskLowW  = 64;
  localparam int unsigned MaskHighW = 16;
  localparam int unsigned MaskW     = MaskLowW + MaskHighW;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;

  // Datapath widths
  localparam int unsigned PixW      = 13;
  localparam int unsigned PadShift  = CoordFracBits + 1;
  localparam int unsigned NumW      = CoordW + 3;
  localparam int unsigned ProdW     = NumW + InvW + 1;
  localparam int unsigned ProdShift = CoordFracBits + 17;
  localparam int unsigned ClipW     = PixW + ProdShift;

  localparam logic [PixW-1:0] PixMax = {PixW{1'b1}};

  typedef enum logic {
    OpGeometry = 1'b0,
    OpScore    = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgConfThreshold = 3'd0,
    CfgInvScale      = 3'd1,
    CfgPadX          = 3'd2,
    CfgPadY          = 3'd3,
    CfgImageWidth    = 3'd4,
    CfgImageHeight   = 3'd5,
    CfgClassMaskLow  = 3'd6,
    CfgClassMaskHigh = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic              operation;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [ScoreW-1:0] class_score;
    logic              last_score;
  } dbd_in_t;

  typedef struct packed {
    logic [PixW-1:0]   left;
    logic [PixW-1:0]   top;
    logic [PixW-1:0]   right;
    logic [PixW-1:0]   bottom;
    logic [ScoreW-1:0] best_score;
    logic [ClassW-1:0] class_id;
  } dbd_out_t;

  typedef struct packed {
    logic [ScoreW-1:0]    conf_threshold;
    logic [InvW-1:0]      inv_scale;
    logic [PadW-1:0]      pad_x;
    logic [PadW-1:0]      pad_y;
    logic [SizeW-1:0]     image_width;
    logic [SizeW-1:0]     image_height;
    logic [MaskLowW-1:0]  class_mask_low;
    logic [MaskHighW-1:0] class_mask_high;
  } dbd_cfg_t;

  // Corner numerators and clip limits of one kept prediction
  typedef struct packed {
    logic signed [NumW-1:0] num_xl;
    logic signed [NumW-1:0] num_xh;
    logic signed [NumW-1:0] num_yl;
    logic signed [NumW-1:0] num_yh;
    logic [PixW-1:0]        lim_x;
    logic [PixW-1:0]        lim_y;
    logic [ScoreW-1:0]      score;
    logic [ClassW-1:0]      class_id;
  } dbd_s1_t;

  // Stage advance enables of the corner pipeline
  typedef struct packed {
    logic s2;
    logic s3;
  } dbd_adv_t;

  // Clip limit is size minus one, held within the pixel range
  function automatic logic [PixW-1:0] clip_limit(input logic [SizeW-1:0] size);
    logic [SizeW-1:0] lim;
    lim = (size == '0) ? '0 : size - SizeW'(1);
    if (lim > SizeW'(PixMax)) begin
      return PixMax;
    end
    return lim[PixW-1:0];
  endfunction

endpackage

[rtl/detection_box_decode.sv]
// Top level of the detection box decoder.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): a geometry beat latches
//   box center and size and starts a prediction; score beats follow in class
//   order and the one with last_score set closes it.
//   Output channel (out_valid_o / out_ready_i / out_data_o): one box beat for
//   each kept prediction with a non-empty box; dropped predictions produce nothing.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i): always
//   ready; write only while no prediction is in flight.
// Throughput: one input beat per cycle while in_ready_o is high. The running argmax
//   is a single compare in the input stage.
// Pipeline: from the edge that accepts its last score beat, a box moves through the
//   numerator, product and clip stages, then the output register, to out_valid_o.
// Stall: each pipeline stage holds while the next one is full, so input beats
//   keep flowing while bubbles remain; in_ready_o drops only when the numerator
//   stage is full and cannot move.
// Reset: the config and control registers take their default values, held geometry and the running
//   argmax clear to zero, and the pipeline empties.
`timescale 1ns / 1ps

module detection_box_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dbd_pkg::dbd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dbd_pkg::dbd_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dbd_pkg::CfgDataW-1:0]  cfg_data_i
);

  dbd_pkg::dbd_cfg_t cfg;
  dbd_pkg::dbd_s1_t  s1;
  dbd_pkg::dbd_adv_t adv;
  logic              s1_valid;
  logic              s1_ready, s2_ready, s3_ready, out_free;
  logic              s2_valid_q, s3_valid_q, out_valid_q;
  logic              in_accept;

  logic [dbd_pkg::ScoreW-1:0] s2_score_q, s3_score_q;
  logic [dbd_pkg::ClassW-1:0] s2_class_q, s3_class_q;
  logic [dbd_pkg::ClipW-1:0]  x_lo, x_hi, y_lo, y_hi, dx, dy;
  logic [dbd_pkg::PixW-1:0]   left, top;
  logic                       empty;
  dbd_pkg::dbd_out_t          out_d, out_q;

  dbd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Elastic stage control, back from the output register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s3_ready   = !s3_valid_q || out_free;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign in_ready_o = s1_ready;
  assign in_accept  = in_valid_i && in_ready_o;
  assign adv.s2     = s2_ready;
  assign adv.s3     = s3_ready;

  dbd_argmax u_argmax (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .s1_ready_i  (s1_ready),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1)
  );

  dbd_axis u_axis_x (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .num_lo_i    (s1.num_xl),
    .num_hi_i    (s1.num_xh),
    .lim_i       (s1.lim_x),
    .inv_scale_i (cfg.inv_scale),
    .lo_o        (x_lo),
    .hi_o        (x_hi)
  );

  dbd_axis u_axis_y (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .num_lo_i    (s1.num_yl),
    .num_hi_i    (s1.num_yh),
    .lim_i       (s1.lim_y),
    .inv_scale_i (cfg.inv_scale),
    .lo_o        (y_lo),
    .hi_o        (y_hi)
  );

  // Carry score and class alongside the corner pipeline
  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_score_q <= s1.score;
      s2_class_q <= s1.class_id;
    end
    if (s3_ready) begin
      s3_score_q <= s2_score_q;
      s3_class_q <= s2_class_q;
    end
  end

  // Drop empty boxes, truncate corners and sizes to whole pixels
  assign empty = (x_hi <= x_lo) || (y_hi <= y_lo);
  assign dx    = x_hi - x_lo;
  assign dy    = y_hi - y_lo;
  assign left  = x_lo[dbd_pkg::ClipW-1:dbd_pkg::ProdShift];
  assign top   = y_lo[dbd_pkg::ClipW-1:dbd_pkg::ProdShift];

  always_comb begin
    out_d.left       = left;
    out_d.top        = top;
    out_d.right      = left + dx[dbd_pkg::ClipW-1:dbd_pkg::ProdShift];
    out_d.bottom     = top + dy[dbd_pkg::ClipW-1:dbd_pkg::ProdShift];
    out_d.best_score = s3_score_q;
    out_d.class_id   = s3_class_q;
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_free) begin
        out_valid_q <= s3_valid_q && !empty;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/dbd_cfg.sv]
// Configuration register file of the detection box decoder.
`timescale 1ns / 1ps

module dbd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dbd_pkg::CfgDataW-1:0]  cfg_data_i,
  output dbd_pkg::dbd_cfg_t             cfg_o
);

  dbd_pkg::dbd_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index and take the low bits of the write data
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (dbd_pkg::cfg_idx_e'(cfg_index_i))
        dbd_pkg::CfgConfThreshold: cfg_d.conf_threshold  = cfg_data_i[dbd_pkg::ScoreW-1:0];
        dbd_pkg::CfgInvScale:      cfg_d.inv_scale       = cfg_data_i[dbd_pkg::InvW-1:0];
        dbd_pkg::CfgPadX:          cfg_d.pad_x           = cfg_data_i[dbd_pkg::PadW-1:0];
        dbd_pkg::CfgPadY:          cfg_d.pad_y           = cfg_data_i[dbd_pkg::PadW-1:0];
        dbd_pkg::CfgImageWidth:    cfg_d.image_width     = cfg_data_i[dbd_pkg::SizeW-1:0];
        dbd_pkg::CfgImageHeight:   cfg_d.image_height    = cfg_data_i[dbd_pkg::SizeW-1:0];
        dbd_pkg::CfgClassMaskLow:  cfg_d.class_mask_low  = cfg_data_i[dbd_pkg::MaskLowW-1:0];
        dbd_pkg::CfgClassMaskHigh: cfg_d.class_mask_high = cfg_data_i[dbd_pkg::MaskHighW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Hold registers, reset to the power-on defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_threshold  <= dbd_pkg::ScoreW'(16384);
      cfg_q.inv_scale       <= dbd_pkg::InvW'(65536);
      cfg_q.pad_x           <= '0;
      cfg_q.pad_y           <= '0;
      cfg_q.image_width     <= dbd_pkg::SizeW'(640);
      cfg_q.image_height    <= dbd_pkg::SizeW'(640);
      cfg_q.class_mask_low  <= '1;
      cfg_q.class_mask_high <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/dbd_argmax.sv]
// Input stage: geometry hold, running argmax and corner numerators.
`timescale 1ns / 1ps

module dbd_argmax (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dbd_pkg::dbd_cfg_t cfg_i,
  input  logic              in_accept_i,
  input  dbd_pkg::dbd_in_t  in_data_i,
  input  logic              s1_ready_i,
  output logic              s1_valid_o,
  output dbd_pkg::dbd_s1_t  s1_o
);

  logic [dbd_pkg::CoordW-1:0] held_cx_q, held_cy_q, held_w_q, held_h_q;
  logic [dbd_pkg::ScoreW-1:0] max_q, max_d;
  logic [dbd_pkg::ClassW-1:0] cls_q, cls_d;
  logic [dbd_pkg::ClassW-1:0] cnt_q, cnt_d;
  logic                       found_q, found_d;
  logic                       s1_valid_q, s1_valid_d;
  dbd_pkg::dbd_s1_t           s1_q, s1_d;

  logic                       is_score;
  logic                       is_last;
  logic [dbd_pkg::ScoreW-1:0] upd_max;
  logic [dbd_pkg::ClassW-1:0] upd_cls;
  logic                       upd_found;
  logic [dbd_pkg::MaskW-1:0]  mask;
  logic                       allowed;
  logic                       keep;
  logic [dbd_pkg::NumW-1:0]   cx2, cy2, wx, hy, px, py;

  assign is_score = (in_data_i.operation == dbd_pkg::OpScore);
  assign is_last  = is_score && in_data_i.last_score;
  assign mask     = {cfg_i.class_mask_high, cfg_i.class_mask_low};

  // Fold this score into the running argmax, first strict maximum wins
  always_comb begin
    upd_max   = max_q;
    upd_cls   = cls_q;
    upd_found = found_q;
    cnt_d     = cnt_q;
    if (cnt_q < dbd_pkg::ClassW'(dbd_pkg::ClassCount)) begin
      if (in_data_i.class_score > max_q) begin
        upd_max   = in_data_i.class_score;
        upd_cls   = cnt_q;
        upd_found = 1'b1;
      end
      cnt_d = cnt_q + dbd_pkg::ClassW'(1);
    end
  end

  // Keep test on the final argmax
  assign allowed = (upd_cls < dbd_pkg::ClassW'(dbd_pkg::MaskW)) && mask[upd_cls];
  assign keep    = upd_found && (upd_max >= cfg_i.conf_threshold) && allowed;

  // Corner numerators: twice the center, minus or plus the size, less the padding
  assign cx2 = dbd_pkg::NumW'(held_cx_q) << 1;
  assign cy2 = dbd_pkg::NumW'(held_cy_q) << 1;
  assign wx  = dbd_pkg::NumW'(held_w_q);
  assign hy  = dbd_pkg::NumW'(held_h_q);
  assign px  = dbd_pkg::NumW'(cfg_i.pad_x) << dbd_pkg::PadShift;
  assign py  = dbd_pkg::NumW'(cfg_i.pad_y) << dbd_pkg::PadShift;

  always_comb begin
    s1_d.num_xl   = $signed(cx2 - wx - px);
    s1_d.num_xh   = $signed(cx2 + wx - px);
    s1_d.num_yl   = $signed(cy2 - hy - py);
    s1_d.num_yh   = $signed(cy2 + hy - py);
    s1_d.lim_x    = dbd_pkg::clip_limit(cfg_i.image_width);
    s1_d.lim_y    = dbd_pkg::clip_limit(cfg_i.image_height);
    s1_d.score    = upd_max;
    s1_d.class_id = upd_cls;
  end

  // Next running state: clear on geometry and after the last score
  always_comb begin
    max_d   = max_q;
    cls_d   = cls_q;
    found_d = found_q;
    if (in_accept_i) begin
      if (!is_score || is_last) begin
        max_d   = '0;
        cls_d   = '0;
        found_d = 1'b0;
      end else begin
        max_d   = upd_max;
        cls_d   = upd_cls;
        found_d = upd_found;
      end
    end
  end

  // Stage one valid: load a kept prediction, drain when downstream takes it
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_ready_i) begin
      s1_valid_d = in_accept_i && is_last && keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cx_q  <= '0;
      held_cy_q  <= '0;
      held_w_q   <= '0;
      held_h_q   <= '0;
      max_q      <= '0;
      cls_q      <= '0;
      found_q    <= 1'b0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      max_q      <= max_d;
      cls_q      <= cls_d;
      found_q    <= found_d;
      s1_valid_q <= s1_valid_d;
      if (in_accept_i) begin
        if (!is_score) begin
          held_cx_q <= in_data_i.center_x;
          held_cy_q <= in_data_i.center_y;
          held_w_q  <= in_data_i.box_width;
          held_h_q  <= in_data_i.box_height;
          cnt_q     <= '0;
        end else if (is_last) begin
          cnt_q     <= '0;
        end else begin
          cnt_q     <= cnt_d;
        end
      end
    end
  end

  // Stage one payload
  always_ff @(posedge clk_i) begin
    if (in_accept_i && is_last) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

[rtl/dbd_axis.sv]
// Corner pipeline of one axis: scale by the reciprocal, then clip.
`timescale 1ns / 1ps

module dbd_axis (
  input  logic                               clk_i,
  input  dbd_pkg::dbd_adv_t                  adv_i,
  input  logic signed [dbd_pkg::NumW-1:0]    num_lo_i,
  input  logic signed [dbd_pkg::NumW-1:0]    num_hi_i,
  input  logic        [dbd_pkg::PixW-1:0]    lim_i,
  input  logic        [dbd_pkg::InvW-1:0]    inv_scale_i,
  output logic        [dbd_pkg::ClipW-1:0]   lo_o,
  output logic        [dbd_pkg::ClipW-1:0]   hi_o
);

  logic signed [dbd_pkg::InvW:0]    inv_s;
  logic signed [dbd_pkg::ProdW-1:0] prod_lo_d, prod_hi_d, prod_lo_q, prod_hi_q;
  logic        [dbd_pkg::PixW-1:0]  lim_q;
  logic signed [dbd_pkg::ProdW-1:0] lim_full;
  logic        [dbd_pkg::ClipW-1:0] lo_d, hi_d, lo_q, hi_q;

  // Scale both numerators
  assign inv_s     = $signed({1'b0, inv_scale_i});
  assign prod_lo_d = dbd_pkg::ProdW'(num_lo_i) * dbd_pkg::ProdW'(inv_s);
  assign prod_hi_d = dbd_pkg::ProdW'(num_hi_i) * dbd_pkg::ProdW'(inv_s);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      lim_q     <= lim_i;
    end
  end

  // Clip both products to zero and the limit at full precision
  assign lim_full = $signed(dbd_pkg::ProdW'(lim_q) << dbd_pkg::ProdShift);

  always_comb begin
    if (prod_lo_q < 0) begin
      lo_d = '0;
    end else if (prod_lo_q > lim_full) begin
      lo_d = lim_full[dbd_pkg::ClipW-1:0];
    end else begin
      lo_d = prod_lo_q[dbd_pkg::ClipW-1:0];
    end
    if (prod_hi_q < 0) begin
      hi_d = '0;
    end else if (prod_hi_q > lim_full) begin
      hi_d = lim_full[dbd_pkg::ClipW-1:0];
    end else begin
      hi_d = prod_hi_q[dbd_pkg::ClipW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule
